FILE: sv/crd_pkg.sv
package crd_pkg;

  // pixel coordinates
  localparam int PIX_W   = 12;
  localparam int MAX_DIM = 4096;

  // generator
  localparam int RNG_W = 48;
  localparam logic [RNG_W-1:0] LCG_A = 48'h0005DEECE66D;
  localparam logic [RNG_W-1:0] LCG_C = 48'h00000000000B;
  // two steps folded into one: s2 = A^2*s + (A*C + C)
  localparam logic [2*RNG_W-1:0] LCG_AA = 96'(LCG_A) * 96'(LCG_A);
  localparam logic [2*RNG_W-1:0] LCG_AC = 96'(LCG_A) * 96'(LCG_C) + 96'(LCG_C);
  localparam logic [RNG_W-1:0] LCG_A2 = LCG_AA[RNG_W-1:0];
  localparam logic [RNG_W-1:0] LCG_C2 = LCG_AC[RNG_W-1:0];

  // configuration
  localparam int CMP_W     = 21;
  localparam int VEC_W     = 3 * CMP_W;
  localparam int RCP_W     = 25;
  localparam int AR_W      = 21;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_H   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT  = 3'd5;

  // normalize / sqrt / divide
  localparam int DFB    = 16;
  localparam int OUT_W  = DFB + 2;
  localparam int MAG_W  = 31;
  localparam int RAD_W  = 2 * MAG_W;
  localparam int ROOT_W = MAG_W;
  localparam int SQ_ST  = RAD_W / 2;
  localparam int QW     = DFB + 1;
  localparam int NUM_W  = MAG_W + DFB;

  typedef struct packed {
    logic                        vld;
    logic                        zero;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
    logic [RNG_W-1:0]            rng;
  } sq_side_t;

  typedef struct packed {
    logic             vld;
    logic             zero;
    logic [2:0]       neg;
    logic [RNG_W-1:0] rng;
  } dv_side_t;

endpackage

FILE: sv/camera_ray_direction.sv
// Pinhole camera primary-ray generator. Each beat on the input channel carries a pixel
// (x, y), a jitter flag and a 48-bit erand48 state; each output beat carries the unit
// ray direction in signed Q1.16 (saturated to +/-1.0) and the advanced generator state
// (two draws with jitter, unchanged without). With jitter the pixel is offset by up to
// half a pixel spacing along the camera right and up axes. One beat is accepted every
// clock while the pipe moves; the whole pipe moves together, whenever the output
// register is empty or being drained, so in_ready follows out_ready. It has 13 front
// stages, 31 square-root stages, one divide setup stage, 17 divide stages and one
// output register; square root and divider resolve one bit per stage. Configuration
// (camera basis, reciprocal image size, aspect ratio) must be written while idle.
module camera_ray_direction (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [crd_pkg::PIX_W-1:0]           in_pixel_x,
  input  logic [crd_pkg::PIX_W-1:0]           in_pixel_y,
  input  logic                                in_jitter_enable,
  input  logic [crd_pkg::RNG_W-1:0]           in_rng_state,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [crd_pkg::OUT_W-1:0]    out_dir_x,
  output logic signed [crd_pkg::OUT_W-1:0]    out_dir_y,
  output logic signed [crd_pkg::OUT_W-1:0]    out_dir_z,
  output logic [crd_pkg::RNG_W-1:0]           out_rng_next,
  input  logic                                cfg_we,
  input  logic [crd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crd_pkg::VEC_W-1:0]           cfg_wdata
);
  import crd_pkg::*;

  // ---------------- configuration ----------------
  logic [VEC_W-1:0] fwd_r, rgt_r, up_r;
  logic [RCP_W-1:0] iw_r, ih_r;
  logic [AR_W-1:0]  ar_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= '0;
      rgt_r <= '0;
      up_r  <= '0;
      iw_r  <= RCP_W'(16384);
      ih_r  <= RCP_W'(21845);
      ar_r  <= AR_W'(87381);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORWARD: fwd_r <= cfg_wdata;
        CFG_RIGHT:   rgt_r <= cfg_wdata;
        CFG_UP:      up_r  <= cfg_wdata;
        CFG_INV_W:   iw_r  <= cfg_wdata[RCP_W-1:0];
        CFG_INV_H:   ih_r  <= cfg_wdata[RCP_W-1:0];
        CFG_ASPECT:  ar_r  <= cfg_wdata[AR_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances together
  logic pipe_en;
  logic out_valid_r;
  assign pipe_en  = out_ready | ~out_valid_r;
  assign in_ready = pipe_en;

  // ---------------- S1: generator partial products ----------------
  // (K*s) mod 2^48 from 24-bit halves; the high*high term falls off.
  logic             v1_r, jit1_r;
  logic [PIX_W-1:0] px1_r, py1_r, px_nxt, py_nxt;
  logic [RNG_W-1:0] rng1_r, ll1_r, ll2_r, ll1_nxt, ll2_nxt;
  logic [23:0]      md1_r, md2_r, md1_nxt, md2_nxt;

  always_comb begin
    px_nxt  = ({1'b0, in_pixel_x} >= (PIX_W+1)'(MAX_DIM)) ? PIX_W'(MAX_DIM - 1) : in_pixel_x;
    py_nxt  = ({1'b0, in_pixel_y} >= (PIX_W+1)'(MAX_DIM)) ? PIX_W'(MAX_DIM - 1) : in_pixel_y;
    ll1_nxt = 48'(LCG_A[23:0]) * 48'(in_rng_state[23:0]);
    md1_nxt = 24'(LCG_A[47:24] * in_rng_state[23:0]) + 24'(LCG_A[23:0] * in_rng_state[47:24]);
    ll2_nxt = 48'(LCG_A2[23:0]) * 48'(in_rng_state[23:0]);
    md2_nxt = 24'(LCG_A2[47:24] * in_rng_state[23:0])
            + 24'(LCG_A2[23:0] * in_rng_state[47:24]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r   <= in_valid;
      px1_r  <= px_nxt;
      py1_r  <= py_nxt;
      jit1_r <= in_jitter_enable;
      rng1_r <= in_rng_state;
      ll1_r  <= ll1_nxt;
      ll2_r  <= ll2_nxt;
      md1_r  <= md1_nxt;
      md2_r  <= md2_nxt;
    end
  end

  // ---------------- S2: finish both draws ----------------
  logic             v2_r, jit2_r;
  logic [PIX_W-1:0] px2_r, py2_r;
  logic [15:0]      r1_r, r2_r;
  logic [RNG_W-1:0] rng2_r, s1_w, s2_w;

  assign s1_w = ll1_r + {md1_r, 24'b0} + LCG_C;
  assign s2_w = ll2_r + {md2_r, 24'b0} + LCG_C2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (pipe_en) begin
      v2_r   <= v1_r;
      px2_r  <= px1_r;
      py2_r  <= py1_r;
      jit2_r <= jit1_r;
      r1_r   <= s1_w[47:32];
      r2_r   <= s2_w[47:32];
      rng2_r <= jit1_r ? s2_w : rng1_r;
    end
  end

  // ---------------- S3: sample position, Q.17 ----------------
  logic                 v3_r;
  logic [RNG_W-1:0]     rng3_r;
  logic signed [30:0]   tx3_r, ty3_r, tx_nxt, ty_nxt;

  always_comb begin
    tx_nxt = $signed({2'b00, px2_r, 17'b0});
    ty_nxt = $signed({2'b00, py2_r, 17'b0});
    if (jit2_r) begin
      tx_nxt = tx_nxt + $signed({14'b0, r1_r, 1'b0}) - 31'sd65536;
      ty_nxt = ty_nxt + $signed({14'b0, r2_r, 1'b0}) - 31'sd65536;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (pipe_en) begin
      v3_r   <= v2_r;
      rng3_r <= rng2_r;
      tx3_r  <= tx_nxt;
      ty3_r  <= ty_nxt;
    end
  end

  // ---------------- S4: scale by reciprocal size ----------------
  logic               v4_r;
  logic [RNG_W-1:0]   rng4_r;
  logic signed [56:0] pw4_r, ph4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (pipe_en) begin
      v4_r   <= v3_r;
      rng4_r <= rng3_r;
      pw4_r  <= tx3_r * $signed({1'b0, iw_r});
      ph4_r  <= ty3_r * $signed({1'b0, ih_r});
    end
  end

  // ---------------- S5: screen offsets ----------------
  logic               v5_r;
  logic [RNG_W-1:0]   rng5_r;
  logic signed [40:0] a5_r;
  logic signed [33:0] v5v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (pipe_en) begin
      v5_r   <= v4_r;
      rng5_r <= rng4_r;
      a5_r   <= $signed(pw4_r[56:16]) - 41'sd16777216;
      v5v_r  <= 34'sd65536 - $signed(ph4_r[56:24]);
    end
  end

  // ---------------- S6: aspect ratio ----------------
  logic               v6_r;
  logic [RNG_W-1:0]   rng6_r;
  logic signed [38:0] u6_r;
  logic signed [33:0] v6v_r;
  logic signed [62:0] au_w;

  assign au_w = a5_r * $signed({1'b0, ar_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (pipe_en) begin
      v6_r   <= v5_r;
      rng6_r <= rng5_r;
      u6_r   <= $signed(au_w[62:24]);
      v6v_r  <= v5v_r;
    end
  end

  // ---------------- S7: basis products ----------------
  logic               v7_r;
  logic [RNG_W-1:0]   rng7_r;
  logic signed [59:0] pr7_r [3];
  logic signed [54:0] pu7_r [3];
  logic signed [37:0] pf7_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (pipe_en) begin
      v7_r   <= v6_r;
      rng7_r <= rng6_r;
      for (int i = 0; i < 3; i++) begin
        pr7_r[i] <= u6_r * $signed(rgt_r[CMP_W*i +: CMP_W]);
        pu7_r[i] <= v6v_r * $signed(up_r[CMP_W*i +: CMP_W]);
        pf7_r[i] <= $signed({fwd_r[CMP_W*i +: CMP_W], 17'b0});
      end
    end
  end

  // ---------------- S8: direction, Q.33 ----------------
  logic               v8_r;
  logic [RNG_W-1:0]   rng8_r;
  logic signed [61:0] d8_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (pipe_en) begin
      v8_r   <= v7_r;
      rng8_r <= rng7_r;
      for (int i = 0; i < 3; i++) begin
        d8_r[i] <= 62'(pr7_r[i]) + 62'(pu7_r[i]) + 62'(pf7_r[i]);
      end
    end
  end

  // ---------------- S9: largest magnitude ----------------
  logic               v9_r, z9_r;
  logic [RNG_W-1:0]   rng9_r;
  logic signed [61:0] d9_r [3];
  logic [61:0]        m9_r, m_nxt;

  always_comb begin
    logic [61:0] mg;
    m_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mg = d8_r[i][61] ? 62'(-d8_r[i]) : 62'(d8_r[i]);
      if (mg > m_nxt) begin
        m_nxt = mg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (pipe_en) begin
      v9_r   <= v8_r;
      rng9_r <= rng8_r;
      d9_r   <= d8_r;
      m9_r   <= m_nxt;
      z9_r   <= (m_nxt == '0);
    end
  end

  // ---------------- S10: leading one ----------------
  logic               v10_r, z10_r;
  logic [RNG_W-1:0]   rng10_r;
  logic signed [61:0] d10_r [3];
  logic [5:0]         p10_r, p_nxt;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 62; i++) begin
      if (m9_r[i]) begin
        p_nxt = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (pipe_en) begin
      v10_r   <= v9_r;
      rng10_r <= rng9_r;
      d10_r   <= d9_r;
      z10_r   <= z9_r;
      p10_r   <= p_nxt;
    end
  end

  // ---------------- S11: scale so the max lands in [2^29, 2^30] ----------------
  logic                  v11_r, z11_r;
  logic [RNG_W-1:0]      rng11_r;
  logic [2:0]            neg11_r, neg_nxt;
  logic [2:0][MAG_W-1:0] mag11_r, mag_nxt;

  always_comb begin
    logic signed [61:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (p10_r > 6'd29) begin
        sh = d10_r[i] >>> (p10_r - 6'd29);   // floor shift
      end else begin
        sh = d10_r[i] <<< (6'd29 - p10_r);
      end
      neg_nxt[i] = sh[61];
      mag_nxt[i] = sh[61] ? MAG_W'(-sh) : MAG_W'(sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else if (pipe_en) begin
      v11_r   <= v10_r;
      rng11_r <= rng10_r;
      z11_r   <= z10_r;
      neg11_r <= neg_nxt;
      mag11_r <= mag_nxt;
    end
  end

  // ---------------- S12: squares ----------------
  logic                  v12_r, z12_r;
  logic [RNG_W-1:0]      rng12_r;
  logic [2:0]            neg12_r;
  logic [2:0][MAG_W-1:0] mag12_r;
  logic [RAD_W-1:0]      sq12_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
    end else if (pipe_en) begin
      v12_r   <= v11_r;
      rng12_r <= rng11_r;
      z12_r   <= z11_r;
      neg12_r <= neg11_r;
      mag12_r <= mag11_r;
      for (int i = 0; i < 3; i++) begin
        sq12_r[i] <= RAD_W'(mag11_r[i]) * RAD_W'(mag11_r[i]);
      end
    end
  end

  // ---------------- S13: sum of squares ----------------
  sq_side_t         sq13_r;
  logic [RAD_W-1:0] sum13_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq13_r.vld <= 1'b0;
    end else if (pipe_en) begin
      sq13_r.vld  <= v12_r;
      sq13_r.zero <= z12_r;
      sq13_r.neg  <= neg12_r;
      sq13_r.mag  <= mag12_r;
      sq13_r.rng  <= rng12_r;
      sum13_r     <= sq12_r[0] + sq12_r[1] + sq12_r[2];
    end
  end

  // ---------------- length ----------------
  sq_side_t          sq_out;
  logic [ROOT_W-1:0] len_w;

  crd_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_side  (sq13_r),
    .in_rad   (sum13_r),
    .out_side (sq_out),
    .out_root (len_w)
  );

  // ---------------- divide setup: (mag << DFB) + len/2 ----------------
  dv_side_t              ds_r;
  logic [2:0][NUM_W-1:0] num_r;
  logic [ROOT_W-1:0]     den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_r.vld <= 1'b0;
    end else if (pipe_en) begin
      ds_r.vld  <= sq_out.vld;
      ds_r.zero <= sq_out.zero;
      ds_r.neg  <= sq_out.neg;
      ds_r.rng  <= sq_out.rng;
      den_r     <= len_w;
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= {sq_out.mag[i], {DFB{1'b0}}} + NUM_W'(len_w >> 1);
      end
    end
  end

  dv_side_t           dv_out;
  logic [2:0][QW-1:0] quo_w;

  crd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_side  (ds_r),
    .in_num   (num_r),
    .in_den   (den_r),
    .out_side (dv_out),
    .out_quo  (quo_w)
  );

  // ---------------- output register: clamp, sign, zero vector ----------------
  localparam logic [QW-1:0] DIR_LIM = {1'b1, {DFB{1'b0}}};

  logic signed [OUT_W-1:0] dir_nxt [3];
  logic signed [OUT_W-1:0] out_dir_r [3];
  logic [RNG_W-1:0]        out_rng_r;

  always_comb begin
    logic [QW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = (quo_w[i] > DIR_LIM) ? DIR_LIM : quo_w[i];
      if (dv_out.zero) begin
        dir_nxt[i] = '0;
      end else if (dv_out.neg[i]) begin
        dir_nxt[i] = -$signed({1'b0, q});
      end else begin
        dir_nxt[i] = $signed({1'b0, q});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= dv_out.vld;
      out_dir_r   <= dir_nxt;
      out_rng_r   <= dv_out.rng;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dir_x    = out_dir_r[0];
  assign out_dir_y    = out_dir_r[1];
  assign out_dir_z    = out_dir_r[2];
  assign out_rng_next = out_rng_r;

endmodule

FILE: sv/crd_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module crd_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  crd_pkg::sq_side_t           in_side,
  input  logic [crd_pkg::RAD_W-1:0]   in_rad,
  output crd_pkg::sq_side_t           out_side,
  output logic [crd_pkg::ROOT_W-1:0]  out_root
);
  import crd_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  sq_side_t           side_r [SQ_ST];
  logic [REM_W-1:0]   rem_r  [SQ_ST];
  logic [ROOT_W-1:0]  root_r [SQ_ST];
  logic [RAD_W-1:0]   rad_r  [SQ_ST];

  for (genvar j = 0; j < SQ_ST; j++) begin : g_st
    sq_side_t          side_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;

    if (j == 0) begin : g_first
      assign side_i = in_side;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
    end else begin : g_next
      assign side_i = side_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign rad_i  = rad_r[j-1];
    end

    assign cur   = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j].vld <= 1'b0;
      end else if (en) begin
        side_r[j] <= side_i;
        rad_r[j]  <= {rad_i[RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
          rem_r[j]  <= cur - trial;
          root_r[j] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[j]  <= cur;
          root_r[j] <= {root_i[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_side = side_r[SQ_ST-1];
  assign out_root = root_r[SQ_ST-1];

endmodule

FILE: sv/crd_div.sv
// Pipelined restoring divider, three lanes sharing one divisor.
module crd_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  crd_pkg::dv_side_t                      in_side,
  input  logic [2:0][crd_pkg::NUM_W-1:0]         in_num,
  input  logic [crd_pkg::ROOT_W-1:0]             in_den,
  output crd_pkg::dv_side_t                      out_side,
  output logic [2:0][crd_pkg::QW-1:0]            out_quo
);
  import crd_pkg::*;

  dv_side_t               side_r [QW];
  logic [2:0][MAG_W-1:0]  rem_r  [QW];
  logic [2:0][QW-1:0]     low_r  [QW];
  logic [2:0][QW-1:0]     q_r    [QW];
  logic [ROOT_W-1:0]      den_r  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_st
    dv_side_t              side_i;
    logic [2:0][MAG_W-1:0] rem_i;
    logic [2:0][QW-1:0]    low_i;
    logic [2:0][QW-1:0]    q_i;
    logic [ROOT_W-1:0]     den_i;
    logic [2:0][MAG_W-1:0] rem_nxt;
    logic [2:0][QW-1:0]    q_nxt;

    if (j == 0) begin : g_first
      assign side_i = in_side;
      assign den_i  = in_den;
      assign q_i    = '0;
      for (genvar k = 0; k < 3; k++) begin : g_ln
        assign rem_i[k] = {1'b0, in_num[k][NUM_W-1:QW]};
        assign low_i[k] = in_num[k][QW-1:0];
      end
    end else begin : g_next
      assign side_i = side_r[j-1];
      assign den_i  = den_r[j-1];
      assign q_i    = q_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign low_i  = low_r[j-1];
    end

    always_comb begin
      logic [MAG_W:0] cur;
      for (int k = 0; k < 3; k++) begin
        cur = {rem_i[k], low_i[k][QW-1]};
        if (cur >= {1'b0, den_i}) begin
          rem_nxt[k] = MAG_W'(cur - {1'b0, den_i});
          q_nxt[k]   = {q_i[k][QW-2:0], 1'b1};
        end else begin
          rem_nxt[k] = cur[MAG_W-1:0];
          q_nxt[k]   = {q_i[k][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j].vld <= 1'b0;
      end else if (en) begin
        side_r[j] <= side_i;
        den_r[j]  <= den_i;
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
        for (int k = 0; k < 3; k++) begin
          low_r[j][k] <= {low_i[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_side = side_r[QW-1];
  assign out_quo  = q_r[QW-1];

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crd_pkg::*;

  // Write-port indexes past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int  Q17_ONE    = 131072;
  localparam int  DRAIN_WAIT = 80;    // pipe is 63 deep
  localparam int  IDLE_LIMIT = 5000;  // cycles with no beat on either side

  typedef struct {
    logic signed [OUT_W-1:0] x, y, z;
    logic [RNG_W-1:0]        rng;
  } ray_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_x = '0;
  logic [PIX_W-1:0]     in_pixel_y = '0;
  logic                 in_jitter_enable = 1'b0;
  logic [RNG_W-1:0]     in_rng_state = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_dir_x, out_dir_y, out_dir_z;
  logic [RNG_W-1:0]     out_rng_next;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VEC_W-1:0]     cfg_wdata = '0;

  // Local copy of the camera registers, reset values included.
  logic [VEC_W-1:0] cam_fwd = '0, cam_right = '0, cam_up = '0;
  logic [RCP_W-1:0] cam_inv_w = 25'd16384, cam_inv_h = 25'd21845;
  logic [AR_W-1:0]  cam_aspect = 21'd87381;

  ray_t ray_q[$];     // expected rays, oldest first
  int   mismatches = 0;
  bit   steady_flow = 1'b0;  // no gaps or stalls while set
  int   idle_cycles = 0;

  camera_ray_direction DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic longint comp(logic [VEC_W-1:0] vec, int i);
    return longint'(signed'(vec[CMP_W*i +: CMP_W]));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // Ray direction for one pixel under the current camera registers.
  function automatic ray_t predict_ray(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                       logic jit, logic [RNG_W-1:0] seed);
    longint tx, ty, a, u, v, o;
    longint d[3];
    longint unsigned m, sum, len, q, mg;
    int k;
    logic [RNG_W-1:0] s1, s2;
    ray_t r;
    tx = longint'(px) * 131072;
    ty = longint'(py) * 131072;
    r.rng = seed;
    if (jit) begin
      s1 = LCG_A * seed + LCG_C;
      s2 = LCG_A * s1 + LCG_C;
      tx += 2 * longint'(s1[47:32]) - 65536;
      ty += 2 * longint'(s2[47:32]) - 65536;
      r.rng = s2;
    end
    a = ((tx * longint'(cam_inv_w)) >>> 16) - (64'sd1 <<< 24);
    u = (a * longint'(cam_aspect)) >>> 24;
    v = 65536 - ((ty * longint'(cam_inv_h)) >>> 24);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = comp(cam_fwd, i) * 131072 + u * comp(cam_right, i) + v * comp(cam_up, i);
      mg = d[i] < 0 ? -d[i] : d[i];
      if (mg > m) m = mg;
    end
    r.x = '0; r.y = '0; r.z = '0;
    if (m == 0) return r;
    // scale so the largest component lands in [2^29, 2^30]
    k = 0;
    while ((m >> k) >= (64'd1 << 30)) k++;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = d[i] >>> k;
      mg = d[i] < 0 ? -d[i] : d[i];
      if (mg > m) m = mg;
    end
    while (m != 0 && m < (64'd1 << 29)) begin
      m *= 2;
      for (int i = 0; i < 3; i++) d[i] *= 2;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mg = d[i] < 0 ? -d[i] : d[i];
      sum += mg * mg;
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      o = 0;
      if (len != 0) begin
        mg = d[i] < 0 ? -d[i] : d[i];
        q = ((mg << DFB) + len / 2) / len;
        if (q > (64'd1 << DFB)) q = 64'd1 << DFB;   // clamp to +/-1.0
        o = d[i] < 0 ? -longint'(q) : longint'(q);
      end
      case (i)
        0: r.x = OUT_W'(o);
        1: r.y = OUT_W'(o);
        default: r.z = OUT_W'(o);
      endcase
    end
    return r;
  endfunction

  // Expectation is queued on the cycle before the accepting edge; payload is stable.
  always @(negedge clk) begin
    ray_t exp_ray;
    if (rst_n && in_valid && in_ready)
      ray_q.push_back(predict_ray(in_pixel_x, in_pixel_y, in_jitter_enable, in_rng_state));
    if (rst_n && out_valid && out_ready) begin
      if (ray_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat at %0t", $realtime);
      end else begin
        exp_ray = ray_q.pop_front();
        if (out_dir_x !== exp_ray.x || out_dir_y !== exp_ray.y ||
            out_dir_z !== exp_ray.z || out_rng_next !== exp_ray.rng) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: dir exp (%0d %0d %0d) got (%0d %0d %0d) rng exp %h got %h",
                     $realtime, exp_ray.x, exp_ray.y, exp_ray.z,
                     out_dir_x, out_dir_y, out_dir_z, exp_ray.rng, out_rng_next);
        end
      end
    end
    // watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side back-pressure.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  // One input beat; valid stays up into the next call when no gap follows.
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                            logic jit, logic [RNG_W-1:0] seed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pixel_x       <= px;
    in_pixel_y       <= py;
    in_jitter_enable <= jit;
    in_rng_state     <= seed;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_pixel();
    send_pixel(PIX_W'($urandom), PIX_W'($urandom), $urandom_range(0, 3) != 0,
               {16'($urandom), 32'($urandom)});
  endtask

  // Wait for every queued ray, then let the pipe empty.
  task automatic drain_rays();
    in_valid <= 1'b0;
    while (ray_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FORWARD: cam_fwd    = val;
      CFG_RIGHT:   cam_right  = val;
      CFG_UP:      cam_up     = val;
      CFG_INV_W:   cam_inv_w  = val[RCP_W-1:0];
      CFG_INV_H:   cam_inv_h  = val[RCP_W-1:0];
      CFG_ASPECT:  cam_aspect = val[AR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [VEC_W-1:0] pack_vec(int x, int y, int z);
    return {CMP_W'(z), CMP_W'(y), CMP_W'(x)};
  endfunction

  // Near-unit axes most of the time, raw bit patterns otherwise.
  function automatic logic [VEC_W-1:0] random_vec();
    if ($urandom_range(0, 3) == 0) return {31'($urandom), 32'($urandom)};
    return pack_vec($urandom_range(0, 2 * Q17_ONE) - Q17_ONE,
                    $urandom_range(0, 2 * Q17_ONE) - Q17_ONE,
                    $urandom_range(0, 2 * Q17_ONE) - Q17_ONE);
  endfunction

  task automatic set_camera(logic [VEC_W-1:0] f, logic [VEC_W-1:0] r, logic [VEC_W-1:0] u,
                            int iw, int ih, int ar);
    write_reg(CFG_FORWARD, f);
    write_reg(CFG_RIGHT, r);
    write_reg(CFG_UP, u);
    write_reg(CFG_INV_W, VEC_W'(iw));
    write_reg(CFG_INV_H, VEC_W'(ih));
    write_reg(CFG_ASPECT, VEC_W'(ar));
  endtask

  // Reset basis is all zero: every ray is the zero direction; rng still advances with jitter.
  task automatic test_reset_state();
    send_pixel(12'd0, 12'd0, 1'b0, 48'h0);
    send_pixel(12'hFFF, 12'hFFF, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_pixel(12'd320, 12'd240, 1'b1, 48'h0);
    drain_rays();
  endtask

  // Axis-aligned camera: corners, center, jitter at both seed extremes,
  // saturation and junk writes to the unused indexes.
  task automatic test_directed();
    set_camera(pack_vec(0, 0, -Q17_ONE), pack_vec(Q17_ONE, 0, 0), pack_vec(0, Q17_ONE, 0),
               4096, 4096, 65536);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, {31'($urandom), 32'($urandom)});
    send_pixel(12'd0, 12'd0, 1'b0, 48'h0);
    send_pixel(12'hFFF, 12'd0, 1'b0, 48'h0);
    send_pixel(12'd0, 12'hFFF, 1'b0, 48'h0);
    send_pixel(12'hFFF, 12'hFFF, 1'b0, 48'hFFFF_FFFF_FFFF);
    send_pixel(12'd2048, 12'd2048, 1'b0, 48'h0);
    send_pixel(12'd2048, 12'd2048, 1'b1, 48'h0);
    send_pixel(12'd2048, 12'd2048, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_pixel(12'hAAA, 12'h555, 1'b1, 48'hAAAA_AAAA_AAAA);
    send_pixel(12'h555, 12'hAAA, 1'b1, 48'h5555_5555_5555);
    drain_rays();
    // forward and right cancel at the left edge: zero direction
    set_camera(pack_vec(Q17_ONE, 0, 0), pack_vec(Q17_ONE, 0, 0), '0, 0, 0, 131072);
    send_pixel(12'd0, 12'd0, 1'b0, 48'h1);
    send_pixel(12'd7, 12'd9, 1'b0, 48'h2);
    drain_rays();
    // most negative components and widest registers
    set_camera(pack_vec(-1048576, -1048576, -1048576), '1, {1'b0, {62{1'b1}}},
               33554431, 33554431, 2097151);
    send_pixel(12'hFFF, 12'hFFF, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_pixel(12'd0, 12'd0, 1'b1, 48'h0);
    send_pixel(12'd1, 12'hFFE, 1'b0, 48'h0);
    drain_rays();
    set_camera(pack_vec(1048575, 0, 1), '0, '0, 4096, 16777216, 1);
    send_pixel(12'd5, 12'd5, 1'b0, 48'h0);
    send_pixel(12'd5, 12'd5, 1'b1, 48'hFFFF_FFFF_FFFF);
    drain_rays();
  endtask

  // Random cameras (a few at the register extremes) with a burst of pixels each.
  task automatic test_camera_sweep();
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: set_camera(random_vec(), random_vec(), random_vec(), 4096, 4096, 1);
        1: set_camera(random_vec(), random_vec(), random_vec(), 16777216, 16777216, 1048576);
        default: set_camera(random_vec(), random_vec(), random_vec(),
                            $urandom_range(4096, 16777216), $urandom_range(4096, 16777216),
                            $urandom_range(1, 1048576));
      endcase
      steady_flow = (s == 2);   // one burst at full rate
      for (int n = 0; n < 60; n++) begin
        send_random_pixel();
        if (n == 30 && s == 3) begin
          drain_rays();         // sender holds off until the pipe is empty
        end
      end
      steady_flow = 1'b0;
      drain_rays();
    end
  endtask

  // Raster-like runs: consecutive pixels of one row, as a renderer feeds them.
  task automatic test_raster_rows();
    logic [PIX_W-1:0] x0, y0;
    logic [RNG_W-1:0] seed;
    set_camera(random_vec(), random_vec(), random_vec(),
               $urandom_range(4096, 65536), $urandom_range(4096, 65536),
               $urandom_range(32768, 131072));
    for (int row = 0; row < 4; row++) begin
      x0 = PIX_W'($urandom);
      y0 = PIX_W'($urandom);
      seed = {16'($urandom), 32'($urandom)};
      for (int n = 0; n < 20; n++)
        send_pixel(x0 + PIX_W'(n), y0, 1'b1, seed + RNG_W'(n));
    end
    drain_rays();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_camera_sweep();
    test_raster_rows();
    drain_rays();
    if (mismatches == 0 && ray_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
